FILE: design/two_class_priority_deque_macros.svh
// Assertion macros for the two-class priority deque.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef TWO_CLASS_PRIORITY_DEQUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_DEQUE_MACROS_SVH

// Condition holds at every edge outside reset.
`define TCPD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tcpd invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define TCPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcpd implication violated");

// Consequent holds in the cycle after the antecedent.
`define TCPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcpd next-cycle check violated");

`endif

FILE: design/tcpd_pkg.sv
// Shared types and codes for the two-class priority deque.
// No dependencies; used by every module of the block.
package tcpd_pkg;

	localparam int KEY_W    = 16;
	localparam int PROC_W   = 8;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int TDATA_W  = 32;
	localparam int TUSER_W  = 3;

	localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_LIST   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FILTER = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SPLIT  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

	typedef struct packed {
		logic [PROC_W-1:0] proc;
		logic              pref;
		logic [KEY_W-1:0]  key;
	} entry_t;

	// Operands for the shared compare unit.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              pass;
		entry_t            op;
	} cmp_req_t;

	// One result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic                entry_valid;
		entry_t              ent;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} emit_t;

endpackage

FILE: design/tcpd_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on tcpd_pkg for the entry type.
module tcpd_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tcpd_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output tcpd_pkg::entry_t rdata
);

	tcpd_pkg::entry_t mem_q [DEPTH];
	tcpd_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/tcpd_cmp.sv
// Shared compare unit: decides whether the entry on the read port is a hit
// for the running operation. Depends on tcpd_pkg.
module tcpd_cmp (
	input  tcpd_pkg::cmp_req_t req,
	input  tcpd_pkg::entry_t   ent,
	output logic               hit
);

	always_comb begin
		unique case (req.func)
			tcpd_pkg::FUNC_REMOVE: hit = (ent.key == req.op.key);
			tcpd_pkg::FUNC_LIST:   hit = 1'b1;
			tcpd_pkg::FUNC_FILTER: hit = (ent.proc == req.op.proc);
			// preferred entries on the first pass, the rest on the second
			tcpd_pkg::FUNC_SPLIT:  hit = req.pass ? ~ent.pref : ent.pref;
			default:               hit = 1'b0;
		endcase
	end

endmodule

FILE: design/tcpd_ctrl.sv
// Sequencer: walks the entry store one word per cycle for insert shifts, key search,
// delete shifts and listing passes (a listing pass may stall while the output slot is full). Depends on tcpd_pkg.
module tcpd_ctrl #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int CW    = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tcpd_pkg::FUNC_W-1:0]       in_func,
	input  tcpd_pkg::entry_t                  in_entry,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output tcpd_pkg::entry_t                  mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr,
	input  tcpd_pkg::entry_t                  rd_data,
	output tcpd_pkg::cmp_req_t                cmp_req,
	input  logic                              hit,
	input  logic                              slot_free,
	output tcpd_pkg::emit_t                   emit,
	output logic [CW-1:0]                     count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SH,
		ST_SCAN,
		ST_DEL_SH,
		ST_LIST,
		ST_FIN,
		ST_RESP
	} state_t;

	state_t                              state_q, state_d;
	logic [AW-1:0]                       idx_q, idx_d;
	logic [CW-1:0]                       count_q, count_d;
	logic                                pass_q, pass_d;
	logic                                pend_valid_q, pend_valid_d;
	tcpd_pkg::entry_t                    pend_q, pend_d;
	logic [tcpd_pkg::STATUS_W-1:0]       resp_q, resp_d;
	logic [tcpd_pkg::FUNC_W-1:0]         func_q, func_d;
	tcpd_pkg::entry_t                    op_q, op_d;
	logic                                idx_last;
	logic                                is_scan_func;

	assign idx_last     = ((CW'(idx_q) + CW'(1)) == count_q);
	assign is_scan_func = (in_func == tcpd_pkg::FUNC_REMOVE) || (in_func == tcpd_pkg::FUNC_LIST)
		|| (in_func == tcpd_pkg::FUNC_FILTER) || (in_func == tcpd_pkg::FUNC_SPLIT);

	assign in_ready = (state_q == ST_IDLE);
	assign count    = count_q;
	assign cmp_req  = '{func: func_q, pass: pass_q, op: op_q};

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		count_d      = count_q;
		pass_d       = pass_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		resp_d       = resp_q;
		func_d       = func_q;
		op_d         = op_q;
		mem_we       = 1'b0;
		mem_waddr    = idx_q;
		mem_wdata    = rd_data;
		mem_re       = 1'b0;
		mem_raddr    = idx_q;
		emit         = '0;
		emit.count   = tcpd_pkg::COUNT_W'(count_q);

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_d = in_func;
					op_d   = in_entry;
					if (in_func == tcpd_pkg::FUNC_ADD) begin
						if (count_q == CW'(DEPTH)) begin
							resp_d  = tcpd_pkg::STATUS_FULL;
							state_d = ST_RESP;
						end else if (in_entry.pref) begin
							// shift from the back toward the front
							idx_d     = AW'(count_q);
							mem_re    = 1'b1;
							mem_raddr = AW'(count_q - CW'(1));
							state_d   = ST_ADD_SH;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = AW'(count_q);
							mem_wdata = in_entry;
							count_d   = count_q + CW'(1);
							resp_d    = tcpd_pkg::STATUS_OK;
							state_d   = ST_RESP;
						end
					end else if (is_scan_func) begin
						if (count_q == '0) begin
							resp_d  = tcpd_pkg::STATUS_EMPTY;
							state_d = ST_RESP;
						end else begin
							mem_re       = 1'b1;
							mem_raddr    = '0;
							idx_d        = '0;
							pass_d       = 1'b0;
							pend_valid_d = 1'b0;
							state_d      = (in_func == tcpd_pkg::FUNC_REMOVE) ? ST_SCAN : ST_LIST;
						end
					end else begin
						resp_d  = tcpd_pkg::STATUS_OK;
						state_d = ST_RESP;
					end
				end
			end
			ST_ADD_SH: begin
				mem_we = 1'b1;
				if (idx_q == '0) begin
					mem_waddr = '0;
					mem_wdata = op_q;
					count_d   = count_q + CW'(1);
					resp_d    = tcpd_pkg::STATUS_OK;
					state_d   = ST_RESP;
				end else begin
					mem_waddr = idx_q;
					mem_wdata = rd_data;
					mem_re    = 1'b1;
					mem_raddr = idx_q - AW'(2);
					idx_d     = idx_q - AW'(1);
				end
			end
			ST_SCAN: begin
				if (hit) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					state_d   = ST_DEL_SH;
				end else if (idx_last) begin
					resp_d  = tcpd_pkg::STATUS_NOTFOUND;
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_d     = idx_q + AW'(1);
				end
			end
			ST_DEL_SH: begin
				if (!idx_last) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = rd_data;
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(2);
					idx_d     = idx_q + AW'(1);
				end else begin
					count_d = count_q - CW'(1);
					resp_d  = tcpd_pkg::STATUS_OK;
					state_d = ST_RESP;
				end
			end
			ST_LIST: begin
				// hold one hit back so the final beat can carry last
				if (!(hit && pend_valid_q && !slot_free)) begin
					if (hit) begin
						pend_d       = rd_data;
						pend_valid_d = 1'b1;
						if (pend_valid_q) begin
							emit.valid       = 1'b1;
							emit.status      = tcpd_pkg::STATUS_OK;
							emit.entry_valid = 1'b1;
							emit.ent         = pend_q;
							emit.last        = 1'b0;
						end
					end
					if (idx_last) begin
						if ((func_q == tcpd_pkg::FUNC_SPLIT) && !pass_q) begin
							pass_d    = 1'b1;
							idx_d     = '0;
							mem_re    = 1'b1;
							mem_raddr = '0;
						end else begin
							state_d = ST_FIN;
						end
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q + AW'(1);
						idx_d     = idx_q + AW'(1);
					end
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					emit.valid = 1'b1;
					emit.last  = 1'b1;
					if (pend_valid_q) begin
						emit.status      = tcpd_pkg::STATUS_OK;
						emit.entry_valid = 1'b1;
						emit.ent         = pend_q;
					end else begin
						emit.status = tcpd_pkg::STATUS_NOTFOUND;
					end
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					emit.valid  = 1'b1;
					emit.status = resp_q;
					emit.last   = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			pass_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			resp_q       <= tcpd_pkg::STATUS_OK;
			func_q       <= tcpd_pkg::FUNC_ADD;
			op_q         <= '0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			count_q      <= count_d;
			pass_q       <= pass_d;
			pend_valid_q <= pend_valid_d;
			pend_q       <= pend_d;
			resp_q       <= resp_d;
			func_q       <= func_d;
			op_q         <= op_d;
		end
	end

endmodule

FILE: design/two_class_priority_deque.sv
// Two-class priority deque: ordered list of DEPTH entries, one beat at a time.
// Throughput: one item in flight; ready returns the cycle after the last result
// is loaded, as the single sequencer walks the entry store word by word.
// Reset: arst_n clears the sequencer, held count and output valid; the entry
// store is not cleared and needs no clearing pass.
`include "two_class_priority_deque_macros.svh"

module two_class_priority_deque #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beat
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // client_key[15:0], is_preferred[16], procedure_code[24:17]
	input  logic [2:0]  s_axis_tuser,  // func[2:0]
	// result beat
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_key[15:0], out_preferred[16], out_procedure[24:17],
	                                   // entry_count[30:25], zero[31]
	output logic [2:0]  m_axis_tuser,  // status[1:0], entry_valid[2]
	output logic        m_axis_tlast   // last_of_run
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcpd_pkg::entry_t   in_entry;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	tcpd_pkg::entry_t   mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	tcpd_pkg::entry_t   rd_data;
	tcpd_pkg::cmp_req_t cmp_req;
	logic               hit;
	logic               slot_free;
	tcpd_pkg::emit_t    emit;
	logic [CW-1:0]      held_count;
	logic               out_valid_q;
	tcpd_pkg::emit_t    out_q;

	// unpack the input beat
	assign in_entry.key  = s_axis_tdata[15:0];
	assign in_entry.pref = s_axis_tdata[16];
	assign in_entry.proc = s_axis_tdata[24:17];

	tcpd_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	tcpd_cmp u_cmp (
		.req (cmp_req),
		.ent (rd_data),
		.hit (hit)
	);

	tcpd_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_entry  (in_entry),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.rd_data   (rd_data),
		.cmp_req   (cmp_req),
		.hit       (hit),
		.slot_free (slot_free),
		.emit      (emit),
		.count     (held_count)
	);

	// Output register: the sequencer may load a new beat whenever the slot is
	// empty or its current beat is being taken this cycle.
	assign slot_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset; load only with a fresh beat
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_q <= emit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.count, out_q.ent.proc, out_q.ent.pref, out_q.ent.key};
	assign m_axis_tuser  = {out_q.entry_valid, out_q.status};
	assign m_axis_tlast  = out_q.last;

	// The sequencer only produces results while it is busy with an item.
	`TCPD_ASSERT_IMPL(a_emit_only_busy, emit.valid, !s_axis_tready)
	// Every accepted item drops ready in the cycle after it is accepted.
	`TCPD_ASSERT_NEXT(a_accept_drops_ready, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// The held count never runs past the store depth.
	`TCPD_ASSERT_ALWAYS(a_count_bound, held_count <= CW'(DEPTH))

endmodule
